>>> rtl/core/elr_pkg.sv
// ----------------------------------------------------------------------------
// elr_pkg: shared types for the ellipse rasteriser
// Controller states, walk parts, operation codes and the command/status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package elr_pkg;

	// operation carried in s_tuser
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// controller sequence: idle, then the set-up states MUL_A, MUL_B, MUL_T and DEC after a start
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL_A = 5'b00010,
		ST_MUL_B = 5'b00100,
		ST_MUL_T = 5'b01000,
		ST_DEC   = 5'b10000
	} elr_state_t;

	// part of the walk
	typedef enum logic [3:0] {
		W_DONE = 4'b0001,
		W_R1   = 4'b0010,
		W_R2   = 4'b0100,
		W_FIN  = 4'b1000
	} elr_walk_t;

	typedef struct packed {
		logic start;          // latch centre and semi-axes
		logic mul_asq;        // a * a
		logic mul_bsq;        // b * b
		logic mul_t7;         // a * 2b^2
		logic set_dec;        // initial decision terms
		logic step_r1;        // region one row
		logic step_r2;        // region two row
		logic step_fin;       // finish row
		logic fin_from_entry; // finish row taken from cur_y + line flag
		logic out_start;      // all-zero result
		logic out_done;       // done result
	} elr_cmd_t;

	typedef struct packed {
		logic dec2_neg;       // decision two below zero
		logic x_neg;          // x offset below zero
		logic fin_over;       // stored finish row beyond half height
		logic fin_entry_over; // entry finish row beyond half height
	} elr_status_t;

endpackage

>>> rtl/core/ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// ellipse_rasterizer: incremental midpoint ellipse rasteriser
// Top level: stream ports, one-dot mode register, controller and datapath.
// ----------------------------------------------------------------------------
// Every input transfer gives exactly one result transfer. A start transfer
// (tuser 0) latches the centre and semi-axes and returns an all-zero result;
// the block then sets up the decision terms in the states MUL_A, MUL_B,
// MUL_T and DEC on a single shared multiplier (a*a, b*b, a*2b^2, then the
// sums) with s_tready low. Each step transfer (tuser 1) returns one row of
// the four-way symmetric point set: region one, region two, then, with
// one-dot mode off, the vertical run at the centre x up to the half height.
// When the walk has run out, or before any start, a step returns zero
// coordinates with done_res set. Steps flow at one per cycle while results
// are collected; the result sits in an output register and a new transfer
// is taken in the cycle that result is collected. The user must write
// one_dot_mode over the cfg channel only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module ellipse_rasterizer #(
	parameter int AXIS_BITS  = 10,
	parameter int COORD_BITS = 16,
	localparam int S_DATA_W  = ((2 * (COORD_BITS - 1) + 2 * AXIS_BITS + 7) / 8) * 8,
	localparam int M_DATA_W  = ((4 * COORD_BITS + 4 + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // center_x, center_y, semi_a, semi_b, zero pad
	input  logic                s_tuser,  // operation: 0 start, 1 step
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // right_x, left_x, bottom_y, top_y, pixel_mask, pad
	output logic                m_tuser,  // done_res
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data  // one_dot_mode
);

	localparam int CX_W  = COORD_BITS - 1;

	// input fields, lowest first
	logic signed [CX_W-1:0]      center_x, center_y;
	logic        [AXIS_BITS-1:0] semi_a, semi_b;

	assign center_x = s_tdata[CX_W-1:0];
	assign center_y = s_tdata[2*CX_W-1:CX_W];
	assign semi_a   = s_tdata[2*CX_W+AXIS_BITS-1:2*CX_W];
	assign semi_b   = s_tdata[2*CX_W+2*AXIS_BITS-1:2*CX_W+AXIS_BITS];

	// one-dot mode register, always ready; the user must write it only while idle, as this is not enforced
	logic one_dot_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			one_dot_q <= 1'b0;
		else if (cfg_valid)
			one_dot_q <= cfg_data;
	end

	elr_pkg::elr_cmd_t    cmd;
	elr_pkg::elr_status_t sts;

	elr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_op         (s_tuser),
		.s_tready     (s_tready),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.one_dot_mode (one_dot_q),
		.sts          (sts),
		.cmd          (cmd)
	);

	logic [COORD_BITS-1:0] right_x, left_x, bottom_y, top_y;
	logic [3:0]            pixel_mask;
	logic                  done_res;

	elr_datapath #(
		.AXIS_BITS  (AXIS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.center_x     (center_x),
		.center_y     (center_y),
		.semi_a       (semi_a),
		.semi_b       (semi_b),
		.one_dot_mode (one_dot_q),
		.sts          (sts),
		.right_x      (right_x),
		.left_x       (left_x),
		.bottom_y     (bottom_y),
		.top_y        (top_y),
		.pixel_mask   (pixel_mask),
		.done_res     (done_res)
	);

	// result packing, lowest field first, zero padded to whole bytes
	assign m_tdata = M_DATA_W'({pixel_mask, top_y, bottom_y, left_x, right_x});
	assign m_tuser = done_res;

endmodule

>>> rtl/core/elr_datapath.sv
// ----------------------------------------------------------------------------
// elr_datapath: ellipse rasteriser datapath
// Shared multiplier for set-up, decision accumulators, walk registers and
// the result register.
// ----------------------------------------------------------------------------
module elr_datapath #(
	parameter int AXIS_BITS  = 10,
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  elr_pkg::elr_cmd_t             cmd,
	input  logic signed [COORD_BITS-2:0]  center_x,
	input  logic signed [COORD_BITS-2:0]  center_y,
	input  logic        [AXIS_BITS-1:0]   semi_a,
	input  logic        [AXIS_BITS-1:0]   semi_b,
	input  logic                          one_dot_mode,
	output elr_pkg::elr_status_t          sts,
	output logic        [COORD_BITS-1:0]  right_x,
	output logic        [COORD_BITS-1:0]  left_x,
	output logic        [COORD_BITS-1:0]  bottom_y,
	output logic        [COORD_BITS-1:0]  top_y,
	output logic        [3:0]             pixel_mask,
	output logic                          done_res
);

	localparam int CX_W   = COORD_BITS - 1;
	localparam int POS_W  = AXIS_BITS + 3;
	localparam int SQ_W   = 2 * AXIS_BITS;
	localparam int MB_W   = 2 * AXIS_BITS + 1;
	localparam int PROD_W = 3 * AXIS_BITS + 1;
	localparam int TERM_W = 3 * AXIS_BITS + 6;
	localparam int DEC_W  = 4 * AXIS_BITS + 6;
	localparam int SUM_W  = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 1;

	logic signed [CX_W-1:0]   cx_q, cy_q;
	logic        [AXIS_BITS-1:0] hh_q;
	logic signed [POS_W-1:0]  cur_x_q, cur_y_q, fin_row_q;
	logic        [SQ_W-1:0]   a_sq_q, b_sq_q;
	logic signed [TERM_W-1:0] x_term_q, y_term_q;
	logic signed [DEC_W-1:0]  d1_q, d2_q;
	logic                     lw_q;

	// set-up multiplier
	logic [AXIS_BITS-1:0] mul_a_op;
	logic [MB_W-1:0]      mul_b_op;
	logic [PROD_W-1:0]    prod;

	assign mul_a_op = cmd.mul_bsq ? hh_q : cur_x_q[AXIS_BITS-1:0];
	assign mul_b_op = cmd.mul_t7  ? {b_sq_q, 1'b0} :
	                  cmd.mul_bsq ? MB_W'(hh_q) : MB_W'(cur_x_q[AXIS_BITS-1:0]);
	assign prod     = mul_a_op * mul_b_op;

	// increments at term width
	logic signed [TERM_W-1:0] asq_t, bsq_t, yt_inc, xt_dec;
	assign asq_t  = TERM_W'(a_sq_q);
	assign bsq_t  = TERM_W'(b_sq_q);
	assign yt_inc = y_term_q + (asq_t <<< 2);
	assign xt_dec = x_term_q - (bsq_t <<< 2);

	// decision-width views
	logic signed [DEC_W-1:0] asq_d, bsq_d, xt_d, yinc_d, xdec_d;
	assign asq_d  = DEC_W'(a_sq_q);
	assign bsq_d  = DEC_W'(b_sq_q);
	assign xt_d   = DEC_W'(x_term_q);
	assign yinc_d = DEC_W'(yt_inc);
	assign xdec_d = DEC_W'(xt_dec);

	logic d1_neg, d2_neg;
	assign d1_neg = d1_q[DEC_W-1];
	assign d2_neg = d2_q[DEC_W-1];

	// finish row source
	logic signed [POS_W-1:0] fin_entry, fin_row_sel, hh_p;
	assign fin_entry   = cur_y_q + {{(POS_W-1){1'b0}}, lw_q};
	assign fin_row_sel = cmd.fin_from_entry ? fin_entry : fin_row_q;
	assign hh_p        = POS_W'(hh_q);

	assign sts.dec2_neg       = d2_neg;
	assign sts.x_neg          = cur_x_q[POS_W-1];
	assign sts.fin_over       = fin_row_q > hh_p;
	assign sts.fin_entry_over = fin_entry > hh_p;

	// row coordinates; comparisons on exact offsets, sums wrap
	logic signed [SUM_W-1:0] rx_full, lx_full, by_full, ty_full, fby_full, fty_full;
	assign rx_full  = SUM_W'(cx_q) + SUM_W'(cur_x_q);
	assign lx_full  = SUM_W'(cx_q) - SUM_W'(cur_x_q);
	assign by_full  = SUM_W'(cy_q) + SUM_W'(cur_y_q);
	assign ty_full  = SUM_W'(cy_q) - SUM_W'(cur_y_q);
	assign fby_full = SUM_W'(cy_q) + SUM_W'(fin_row_sel);
	assign fty_full = SUM_W'(cy_q) - SUM_W'(fin_row_sel);

	logic x_pos, x_nz, y_pos;
	logic [3:0] walk_mask, fin_mask;
	assign x_pos = cur_x_q > 0;
	assign x_nz  = cur_x_q != 0;
	assign y_pos = cur_y_q > 0;

	always_comb begin
		if (one_dot_mode) begin
			if (x_nz && (cmd.step_r1 || !lw_q))
				walk_mask = {y_pos, y_pos, 2'b11};
			else
				walk_mask = 4'b0000;
		end else begin
			walk_mask = {y_pos & x_pos, y_pos, x_pos, 1'b1};
		end
	end

	assign fin_mask = {1'b0, fin_row_sel > 0, 1'b0, 1'b1};

	// walk and set-up registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cx_q      <= center_x;
			cy_q      <= center_y;
			hh_q      <= semi_b;
			cur_x_q   <= POS_W'(semi_a);
			cur_y_q   <= '0;
			y_term_q  <= '0;
			lw_q      <= 1'b0;
			fin_row_q <= '0;
		end
		if (cmd.mul_asq)
			a_sq_q <= prod[SQ_W-1:0];
		if (cmd.mul_bsq)
			b_sq_q <= prod[SQ_W-1:0];
		if (cmd.mul_t7)
			x_term_q <= TERM_W'({prod, 1'b0});
		if (cmd.set_dec) begin
			d1_q <= (asq_d <<< 1) - (xt_d >>> 1) + bsq_d;
			d2_q <= asq_d - xt_d + (bsq_d <<< 1);
		end
		if (cmd.step_r1) begin
			cur_y_q  <= cur_y_q + 1'b1;
			y_term_q <= yt_inc;
			if (d1_neg) begin
				d1_q <= d1_q + yinc_d + (asq_d <<< 1);
				d2_q <= d2_q + yinc_d;
			end else begin
				cur_x_q  <= cur_x_q - 1'b1;
				x_term_q <= xt_dec;
				d1_q     <= d1_q + yinc_d + (asq_d <<< 1) - xdec_d;
				d2_q     <= d2_q + yinc_d + (bsq_d <<< 1) - xdec_d;
			end
		end
		if (cmd.step_r2) begin
			cur_x_q  <= cur_x_q - 1'b1;
			x_term_q <= xt_dec;
			if (d2_neg) begin
				cur_y_q  <= cur_y_q + 1'b1;
				y_term_q <= yt_inc;
				lw_q     <= 1'b0;
				d2_q     <= d2_q + (bsq_d <<< 1) + yinc_d - xdec_d;
			end else begin
				lw_q <= lw_q | (walk_mask != 4'b0000);
				d2_q <= d2_q + (bsq_d <<< 1) - xdec_d;
			end
		end
		if (cmd.step_fin)
			fin_row_q <= fin_row_sel + 1'b1;
	end

	// result register
	always_ff @(posedge clk) begin
		priority if (cmd.out_start || cmd.out_done) begin
			right_x    <= '0;
			left_x     <= '0;
			bottom_y   <= '0;
			top_y      <= '0;
			pixel_mask <= '0;
			done_res   <= cmd.out_done;
		end else if (cmd.step_r1 || cmd.step_r2) begin
			right_x    <= rx_full[COORD_BITS-1:0];
			left_x     <= lx_full[COORD_BITS-1:0];
			bottom_y   <= by_full[COORD_BITS-1:0];
			top_y      <= ty_full[COORD_BITS-1:0];
			pixel_mask <= walk_mask;
			done_res   <= 1'b0;
		end else if (cmd.step_fin) begin
			right_x    <= COORD_BITS'(cx_q);
			left_x     <= COORD_BITS'(cx_q);
			bottom_y   <= fby_full[COORD_BITS-1:0];
			top_y      <= fty_full[COORD_BITS-1:0];
			pixel_mask <= fin_mask;
			done_res   <= 1'b0;
		end else begin
			done_res <= done_res;
		end
	end

endmodule

>>> rtl/core/elr_ctrl.sv
// ----------------------------------------------------------------------------
// elr_ctrl: ellipse rasteriser controller
// Handshakes, set-up sequence, walk part tracking and datapath commands.
// ----------------------------------------------------------------------------
module elr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_op,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic                 one_dot_mode,
	input  elr_pkg::elr_status_t sts,
	output elr_pkg::elr_cmd_t    cmd
);

	elr_pkg::elr_state_t st_q, st_d;
	elr_pkg::elr_walk_t  walk_q, walk_eff;
	logic                fin_entry;
	logic                acc;

	assign s_tready = (st_q == elr_pkg::ST_IDLE) && (!m_tvalid || m_tready);
	assign acc      = s_tvalid && s_tready;

	// part changes happen within the step that finds the part exhausted
	always_comb begin
		walk_eff  = walk_q;
		fin_entry = 1'b0;
		if (walk_eff == elr_pkg::W_R1 && !sts.dec2_neg) begin
			if (!sts.x_neg) begin
				walk_eff = elr_pkg::W_R2;
			end else if (one_dot_mode) begin
				walk_eff = elr_pkg::W_DONE;
			end else begin
				walk_eff  = elr_pkg::W_FIN;
				fin_entry = 1'b1;
			end
		end
		if (walk_eff == elr_pkg::W_R2 && sts.x_neg) begin
			if (one_dot_mode) begin
				walk_eff = elr_pkg::W_DONE;
			end else begin
				walk_eff  = elr_pkg::W_FIN;
				fin_entry = 1'b1;
			end
		end
		if (walk_eff == elr_pkg::W_FIN) begin
			if (fin_entry ? sts.fin_entry_over : sts.fin_over)
				walk_eff = elr_pkg::W_DONE;
		end
	end

	always_comb begin
		cmd  = '0;
		st_d = st_q;
		unique case (st_q)
			elr_pkg::ST_IDLE: begin
				if (acc) begin
					if (s_op == elr_pkg::OP_START) begin
						cmd.start     = 1'b1;
						cmd.out_start = 1'b1;
						st_d          = elr_pkg::ST_MUL_A;
					end else begin
						cmd.step_r1        = walk_eff == elr_pkg::W_R1;
						cmd.step_r2        = walk_eff == elr_pkg::W_R2;
						cmd.step_fin       = walk_eff == elr_pkg::W_FIN;
						cmd.fin_from_entry = fin_entry;
						cmd.out_done       = walk_eff == elr_pkg::W_DONE;
					end
				end
			end
			elr_pkg::ST_MUL_A: begin
				cmd.mul_asq = 1'b1;
				st_d        = elr_pkg::ST_MUL_B;
			end
			elr_pkg::ST_MUL_B: begin
				cmd.mul_bsq = 1'b1;
				st_d        = elr_pkg::ST_MUL_T;
			end
			elr_pkg::ST_MUL_T: begin
				cmd.mul_t7 = 1'b1;
				st_d       = elr_pkg::ST_DEC;
			end
			elr_pkg::ST_DEC: begin
				cmd.set_dec = 1'b1;
				st_d        = elr_pkg::ST_IDLE;
			end
			default: begin
				st_d = elr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= elr_pkg::ST_IDLE;
			walk_q   <= elr_pkg::W_DONE;
			m_tvalid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (acc) begin
				m_tvalid <= 1'b1;
				walk_q   <= (s_op == elr_pkg::OP_START) ? elr_pkg::W_R1 : walk_eff;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule
